>>> rtl/i2ctrf_pkg.sv
// i2ctrf_pkg: shared types and constants for the i2c target register file
// request and result structs, phase encoding, fixed bus byte codes
// no dependencies
`default_nettype none

package i2ctrf_pkg;

	// default register bank depth
	localparam int NUM_REGS_DEF = 10;

	// event kinds
	localparam logic OP_START    = 1'b0;
	localparam logic OP_OVERFLOW = 1'b1;

	// bytes put on the bus
	localparam logic [7:0] ACK_BYTE  = 8'h00;
	localparam logic [7:0] FILL_BYTE = 8'hF2;

	// bus event request
	typedef struct packed {
		logic       operation;
		logic [7:0] bus_byte;
	} in_req_t;

	// per-event result
	typedef struct packed {
		logic       tx_load;
		logic [7:0] tx_byte;
		logic       sda_drive;
		logic       one_bit_phase;
		logic       released;
	} out_res_t;

	// transfer phase, one-hot
	typedef enum logic [7:0] {
		PH_IDLE      = 8'b0000_0001,
		PH_ADDRESS   = 8'b0000_0010,
		PH_ADDR_ACK  = 8'b0000_0100,
		PH_REGADDR   = 8'b0000_1000,
		PH_WRITE_ACK = 8'b0001_0000,
		PH_WRITE     = 8'b0010_0000,
		PH_READ_ACK  = 8'b0100_0000,
		PH_READ_MULT = 8'b1000_0000
	} phase_t;

endpackage

`default_nettype wire

>>> rtl/i2c_target_register_file.sv
// i2c_target_register_file: byte-level i2c target with an auto-incrementing register bank
// depends on i2ctrf_pkg
//
// Usage
//   in channel (in_valid/in_ready/in_data) carries bus events: a start condition or a
//   shift counter overflow with the shifted byte (bit 0 is the master ack bit after a
//   one-bit phase). Every request yields exactly one result on the out channel
//   (out_valid/out_ready/out_data): byte to load, sda direction, counter preset and a
//   released flag.
//   cfg_wr_en/cfg_wr_data write the seven-bit own address; write it only while no
//   request is in flight. From acceptance to result a request passes the input
//   register, then the phase decode and bank read feed the result register. One
//   request per cycle is sustained while out_ready is high; the phase/pointer/bank
//   update is done in the same cycle as the decode.
//   When the receiver stalls, the result register holds and the input register keeps
//   one more request; in_ready drops only when both are full and out_ready is low.
//   Reset (arst_n low) clears the phase to idle, the direction, the pointer, the own
//   address and all bank registers to zero, and empties both pipeline registers.
`default_nettype none

module i2c_target_register_file
	import i2ctrf_pkg::*;
#(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_wr_en,
	input  wire logic [6:0] cfg_wr_data,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_req_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_res_t      out_data
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [8:0] NUM_REGS_9 = 9'(NUM_REGS);

	logic [6:0]   own_address_q;
	logic         valid_s1;
	in_req_t      req_s1;
	logic         out_valid_q;
	out_res_t     out_data_q;
	phase_t       phase_q;
	phase_t       phase_nx;
	logic         read_dir_q;
	logic         read_dir_nx;
	logic [7:0]   pointer_q;
	logic [7:0]   pointer_nx;
	logic [7:0]   bank_q [NUM_REGS];
	logic         bank_we;
	logic         advance;
	logic         fire;
	logic [7:0]   ptr_inc;
	logic [7:0]   rd_ptr;
	logic [7:0]   rd_byte;
	logic         ptr_in_range;
	out_res_t     res;

	// pipeline flow control
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// own address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_wr_en) begin
			own_address_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	// bank read: current pointer, or the advanced one after a master ack
	assign ptr_inc      = pointer_q + 8'd1;
	assign rd_ptr       = (phase_q == PH_READ_MULT) ? ptr_inc : pointer_q;
	assign rd_byte      = ({1'b0, rd_ptr} < NUM_REGS_9) ? bank_q[rd_ptr[IDX_W-1:0]] : FILL_BYTE;
	assign ptr_in_range = {1'b0, pointer_q} < NUM_REGS_9;

	// phase decode and result
	always_comb begin
		res         = '0;
		phase_nx    = phase_q;
		read_dir_nx = read_dir_q;
		pointer_nx  = pointer_q;
		bank_we     = 1'b0;
		if (req_s1.operation == OP_START) begin
			phase_nx = PH_ADDRESS;
		end else begin
			case (phase_q)
				PH_ADDRESS: begin
					if (req_s1.bus_byte[7:1] == own_address_q) begin
						read_dir_nx       = req_s1.bus_byte[0];
						phase_nx          = PH_ADDR_ACK;
						res.tx_load       = 1'b1;
						res.tx_byte       = ACK_BYTE;
						res.sda_drive     = 1'b1;
						res.one_bit_phase = 1'b1;
					end else begin
						phase_nx     = PH_IDLE;
						res.released = 1'b1;
					end
				end
				PH_ADDR_ACK: begin
					if (read_dir_q) begin
						phase_nx      = PH_READ_ACK;
						res.tx_load   = 1'b1;
						res.tx_byte   = rd_byte;
						res.sda_drive = 1'b1;
					end else begin
						phase_nx = PH_REGADDR;
					end
				end
				PH_REGADDR: begin
					pointer_nx        = req_s1.bus_byte;
					phase_nx          = PH_WRITE_ACK;
					res.tx_load       = 1'b1;
					res.tx_byte       = ACK_BYTE;
					res.sda_drive     = 1'b1;
					res.one_bit_phase = 1'b1;
				end
				PH_WRITE_ACK: begin
					phase_nx = PH_WRITE;
				end
				PH_WRITE: begin
					// out-of-range bytes are dropped but still acknowledged
					if (ptr_in_range) begin
						bank_we    = 1'b1;
						pointer_nx = ptr_inc;
					end
					phase_nx          = PH_WRITE_ACK;
					res.tx_load       = 1'b1;
					res.tx_byte       = ACK_BYTE;
					res.sda_drive     = 1'b1;
					res.one_bit_phase = 1'b1;
				end
				PH_READ_ACK: begin
					phase_nx          = PH_READ_MULT;
					res.one_bit_phase = 1'b1;
				end
				PH_READ_MULT: begin
					// master ack sends the next register, nack goes back to address
					if (!req_s1.bus_byte[0]) begin
						pointer_nx    = ptr_inc;
						phase_nx      = PH_READ_ACK;
						res.tx_load   = 1'b1;
						res.tx_byte   = rd_byte;
						res.sda_drive = 1'b1;
					end else begin
						phase_nx = PH_ADDRESS;
					end
				end
				default: begin
					phase_nx     = PH_IDLE;
					res.released = 1'b1;
				end
			endcase
		end
	end

	// transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			read_dir_q <= 1'b0;
			pointer_q  <= '0;
		end else if (fire) begin
			phase_q    <= phase_nx;
			read_dir_q <= read_dir_nx;
			pointer_q  <= pointer_nx;
		end
	end

	// register bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				bank_q[i] <= '0;
			end
		end else if (fire && bank_we) begin
			bank_q[pointer_q[IDX_W-1:0]] <= req_s1.bus_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// nothing is loaded without a load strobe
	a_byte_zero_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.tx_load |-> out_data_q.tx_byte == 8'h00)
		else $error("tx_byte nonzero without tx_load");

	// a released target never drives the bus
	a_released_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.released |-> !out_data_q.sda_drive && !out_data_q.tx_load)
		else $error("released target drives sda");

	// pointer moves only when a request is processed
	a_pointer_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(pointer_q))
		else $error("pointer changed without a request");

	// in-range data write advances the pointer by one
	a_write_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && bank_we |=> pointer_q == $past(pointer_q) + 8'd1)
		else $error("pointer did not advance after a bank write");

	// a start always re-arms address reception
	a_start_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_s1.operation == OP_START |=> phase_q == PH_ADDRESS)
		else $error("start did not re-arm address phase");

endmodule

`default_nettype wire
